/* sv/triangle_face_normal_scatter_core_macros.svh */
// ----------------------------------------------------------------------------
// triangle face normal scatter assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_FACE_NORMAL_SCATTER_CORE_MACROS_SVH
`define TRIANGLE_FACE_NORMAL_SCATTER_CORE_MACROS_SVH

// same-cycle implication
`define TFN_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("tfn assertion failed");

// next-cycle implication
`define TFN_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("tfn assertion failed");

`endif

/* sv/tfn_pkg.sv */
// ----------------------------------------------------------------------------
// tfn_pkg
// widths, mode codes and result type of the face normal block
// ----------------------------------------------------------------------------
package tfn_pkg;

  localparam int IDX_W   = 12;
  localparam int COORD_W = 16;
  localparam int VTX_W   = 3 * COORD_W;
  localparam int EDGE_W  = 17;
  localparam int PROD_W  = 34;
  localparam int CROSS_W = 35;
  localparam int NORM_W  = 16;
  localparam int NRM3_W  = 3 * NORM_W;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_FACE = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  typedef logic signed [NORM_W-1:0] comp_t;

  typedef struct packed {
    comp_t z;
    comp_t y;
    comp_t x;
    logic  degen;
  } norm_res_t;

endpackage

/* sv/tfn_ram.sv */
// ----------------------------------------------------------------------------
// tfn_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module tfn_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/tfn_norm.sv */
// ----------------------------------------------------------------------------
// tfn_norm
// scales a cross product to unit length: shift, square sum, bitwise square
// root, then three restoring divides
// ----------------------------------------------------------------------------
module tfn_norm
  import tfn_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [2:0][CROSS_W-1:0]     cr,
  output logic                        done,
  output norm_res_t                   res
);

  localparam int MAG_W  = CROSS_W;
  localparam int SQ_W   = 48;
  localparam int X_W    = 64;
  localparam int DIV_W  = 48;
  localparam logic [NORM_W-1:0] QMAX = 16'd16384;

  typedef enum logic [6:0] {
    N_IDLE  = 7'b0000001,
    N_SHIFT = 7'b0000010,
    N_SQ    = 7'b0000100,
    N_ROOT  = 7'b0001000,
    N_DLOAD = 7'b0010000,
    N_DIV   = 7'b0100000,
    N_DONE  = 7'b1000000
  } nstate_t;

  nstate_t                   state_r;
  logic [2:0][MAG_W-1:0]     mag_r;
  logic [2:0]                neg_r;
  logic [MAG_W-1:0]          m_r;
  logic [1:0]                sq_cnt_r;
  logic [SQ_W-1:0]           s_r;
  logic [X_W-1:0]            x_r;
  logic [X_W-1:0]            root_r;
  logic [X_W-1:0]            bit_r;
  logic [1:0]                comp_r;
  logic [3:0]                dcnt_r;
  logic [DIV_W-1:0]          rem_r;
  logic [DIV_W-1:0]          den_r;
  logic [NORM_W-1:0]         q_r;
  comp_t [2:0]               n_r;
  logic                      degen_r;

  logic [2:0][MAG_W-1:0]     abs_c;
  logic [MAG_W-1:0]          max_c;
  logic [45:0]               sq_term;
  logic [SQ_W-1:0]           s_sum;
  logic [X_W-1:0]            root_t;
  logic                      ge;
  logic [NORM_W-1:0]         q_fin;
  logic [NORM_W-1:0]         q_sat;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      abs_c[i] = cr[i][CROSS_W-1] ? MAG_W'(-$signed(cr[i])) : cr[i];
    end
    max_c = abs_c[0];
    if (abs_c[1] > max_c) max_c = abs_c[1];
    if (abs_c[2] > max_c) max_c = abs_c[2];
    sq_term = mag_r[sq_cnt_r][22:0] * mag_r[sq_cnt_r][22:0];
    s_sum   = s_r + SQ_W'(sq_term);
    root_t  = root_r + bit_r;
    ge      = (rem_r >= den_r);
    q_fin   = {q_r[NORM_W-2:0], ge};
    q_sat   = (q_fin > QMAX) ? QMAX : q_fin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
    end else begin
      unique case (state_r)
        N_IDLE: begin
          if (start) begin
            mag_r <= abs_c;
            m_r   <= max_c;
            for (int i = 0; i < 3; i++) begin
              neg_r[i] <= cr[i][CROSS_W-1];
            end
            if (max_c == '0) begin
              n_r     <= '0;
              degen_r <= 1'b1;
              state_r <= N_DONE;
            end else begin
              degen_r <= 1'b0;
              state_r <= N_SHIFT;
            end
          end
        end
        N_SHIFT: begin
          // bring the largest magnitude into [2^22, 2^23)
          if (|m_r[MAG_W-1:23]) begin
            m_r <= m_r >> 1;
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 1;
          end else if (!m_r[22]) begin
            m_r <= m_r << 1;
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] << 1;
          end else begin
            s_r      <= '0;
            sq_cnt_r <= '0;
            state_r  <= N_SQ;
          end
        end
        N_SQ: begin
          s_r      <= s_sum;
          sq_cnt_r <= sq_cnt_r + 2'd1;
          if (sq_cnt_r == 2'd2) begin
            x_r     <= X_W'(s_sum) << 14;
            root_r  <= '0;
            bit_r   <= X_W'(1) << 62;
            state_r <= N_ROOT;
          end
        end
        N_ROOT: begin
          if (x_r >= root_t) begin
            x_r    <= x_r - root_t;
            root_r <= (root_r >> 1) + bit_r;
          end else begin
            root_r <= root_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (bit_r[0]) begin
            comp_r  <= '0;
            state_r <= N_DLOAD;
          end
        end
        N_DLOAD: begin
          // rounded quotient: (mag << 21 + root / 2) / root
          rem_r   <= (DIV_W'(mag_r[comp_r][22:0]) << 21) + DIV_W'(root_r[31:1]);
          den_r   <= DIV_W'(root_r[31:0]) << 15;
          q_r     <= '0;
          dcnt_r  <= '0;
          state_r <= N_DIV;
        end
        N_DIV: begin
          if (ge) rem_r <= rem_r - den_r;
          den_r  <= den_r >> 1;
          q_r    <= q_fin;
          dcnt_r <= dcnt_r + 4'd1;
          if (dcnt_r == 4'd15) begin
            n_r[comp_r] <= neg_r[comp_r] ? comp_t'(-$signed(q_sat)) : comp_t'(q_sat);
            if (comp_r == 2'd2) begin
              state_r <= N_DONE;
            end else begin
              comp_r  <= comp_r + 2'd1;
              state_r <= N_DLOAD;
            end
          end
        end
        N_DONE: begin
          state_r <= N_IDLE;
        end
        default: begin
          state_r <= N_IDLE;
        end
      endcase
    end
  end

  assign done      = (state_r == N_DONE);
  assign res.x     = n_r[0];
  assign res.y     = n_r[1];
  assign res.z     = n_r[2];
  assign res.degen = degen_r;

endmodule

/* sv/triangle_face_normal_scatter_core.sv */
// vertex load: one beat per cycle while idle, written straight into the vertex ram
// normal readout: ram read, capture, then a registered result beat
// face: 3 vertex reads and 6 multiplies, then the 32-step square root and the
//   three 16-step divides of the normalize unit; a normal of zero length
//   skips the normalize steps
// after reset the normal ram is cleared, with in_tready low
// ----------------------------------------------------------------------------
// triangle_face_normal_scatter_core
// vertex and normal rams with a face sequencer: reads three corners, forms
// the cross product, normalizes it and scatters it to the corners
// ----------------------------------------------------------------------------
module triangle_face_normal_scatter_core
  import tfn_pkg::*;
#(
  parameter int VERTEX_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // vertex_index, coord_x, coord_y, coord_z, corner_a, corner_b, corner_c
  input  logic [95:0] in_tdata,
  // mode
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // normal_x, normal_y, normal_z
  output logic [47:0] out_tdata,
  // degenerate, from_face
  output logic [1:0]  out_tuser
);

  localparam int AW = $clog2(VERTEX_DEPTH);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_CLR   = 14'b00000000000010,
    S_NRD   = 14'b00000000000100,
    S_NCAP  = 14'b00000000001000,
    S_VRA   = 14'b00000000010000,
    S_VRB   = 14'b00000000100000,
    S_VRC   = 14'b00000001000000,
    S_VCAP  = 14'b00000010000000,
    S_CROSS = 14'b00000100000000,
    S_NORM  = 14'b00001000000000,
    S_WRA   = 14'b00010000000000,
    S_WRB   = 14'b00100000000000,
    S_WRC   = 14'b01000000000000,
    S_OUT   = 14'b10000000000000
  } state_t;

  function automatic logic in_rng(input logic [IDX_W-1:0] i);
    return 32'(i) < VERTEX_DEPTH;
  endfunction

  state_t                     state_r;
  logic [AW-1:0]              clr_addr_r;
  logic [IDX_W-1:0]           idx_r, ca_r, cb_r, cc_r;
  logic                       va_r, vb_r, vc_r, vi_r;
  logic [VTX_W-1:0]           pa_r, pb_r;
  logic signed [EDGE_W-1:0]   e1_r [3];
  logic signed [EDGE_W-1:0]   e2_r [3];
  logic signed [CROSS_W-1:0]  cr_r [3];
  logic signed [PROD_W-1:0]   prod_r;
  logic [2:0]                 cnt_r;
  logic                       start_r;
  norm_res_t                  res_r;
  logic                       face_r;
  logic                       out_tvalid_r;
  logic [NRM3_W-1:0]          out_tdata_r;
  logic [1:0]                 out_tuser_r;

  logic                       in_acc;
  logic [IDX_W-1:0]           in_idx;
  logic                       v_we;
  logic [AW-1:0]              v_raddr;
  logic [VTX_W-1:0]           v_rdata;
  logic [VTX_W-1:0]           pc_c;
  logic                       n_we;
  logic [AW-1:0]              n_waddr;
  logic [NRM3_W-1:0]          n_wdata;
  logic [NRM3_W-1:0]          n_rdata;
  logic signed [EDGE_W-1:0]   op_a, op_b;
  logic [2:0]                 acc_ix;
  logic signed [CROSS_W-1:0]  prod_ext;
  logic [2:0][CROSS_W-1:0]    cr_pk;
  logic                       norm_done;
  norm_res_t                  norm_res;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_idx    = in_tdata[11:0];
  assign v_we      = in_acc && (in_tuser == MODE_LOAD) && in_rng(in_idx);

  always_comb begin
    unique case (state_r)
      S_VRB:   v_raddr = AW'(cb_r);
      S_VRC:   v_raddr = AW'(cc_r);
      default: v_raddr = AW'(ca_r);
    endcase
  end

  tfn_ram #(.WIDTH(VTX_W), .DEPTH(VERTEX_DEPTH)) u_vtx_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (AW'(in_idx)),
    .wdata (in_tdata[59:12]),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  always_comb begin
    n_we    = 1'b0;
    n_waddr = AW'(ca_r);
    n_wdata = {res_r.z, res_r.y, res_r.x};
    unique case (state_r)
      S_CLR: begin
        n_we    = 1'b1;
        n_waddr = clr_addr_r;
        n_wdata = '0;
      end
      S_WRA: begin
        n_we    = va_r;
        n_waddr = AW'(ca_r);
      end
      S_WRB: begin
        n_we    = vb_r;
        n_waddr = AW'(cb_r);
      end
      S_WRC: begin
        n_we    = vc_r;
        n_waddr = AW'(cc_r);
      end
      default: begin
      end
    endcase
  end

  tfn_ram #(.WIDTH(NRM3_W), .DEPTH(VERTEX_DEPTH)) u_nrm_ram (
    .clk   (clk),
    .we    (n_we),
    .waddr (n_waddr),
    .wdata (n_wdata),
    .raddr (AW'(idx_r)),
    .rdata (n_rdata)
  );

  // one multiply per cycle, operands picked by step
  always_comb begin
    case (cnt_r)
      3'd0:    begin op_a = e1_r[1]; op_b = e2_r[2]; end
      3'd1:    begin op_a = e1_r[2]; op_b = e2_r[1]; end
      3'd2:    begin op_a = e1_r[2]; op_b = e2_r[0]; end
      3'd3:    begin op_a = e1_r[0]; op_b = e2_r[2]; end
      3'd4:    begin op_a = e1_r[0]; op_b = e2_r[1]; end
      3'd5:    begin op_a = e1_r[1]; op_b = e2_r[0]; end
      default: begin op_a = '0;      op_b = '0;      end
    endcase
    acc_ix   = cnt_r - 3'd1;
    prod_ext = CROSS_W'(prod_r);
    pc_c     = vc_r ? v_rdata : '0;
  end

  assign cr_pk = {cr_r[2], cr_r[1], cr_r[0]};

  tfn_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .cr    (cr_pk),
    .done  (norm_done),
    .res   (norm_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_addr_r   <= '0;
      start_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      start_r <= 1'b0;
      if (out_tvalid_r && out_tready && (state_r != S_OUT)) out_tvalid_r <= 1'b0;
      unique case (state_r)
        S_CLR: begin
          clr_addr_r <= clr_addr_r + AW'(1);
          if (clr_addr_r == AW'(VERTEX_DEPTH - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            idx_r <= in_idx;
            vi_r  <= in_rng(in_idx);
            ca_r  <= in_tdata[71:60];
            cb_r  <= in_tdata[83:72];
            cc_r  <= in_tdata[95:84];
            va_r  <= in_rng(in_tdata[71:60]);
            vb_r  <= in_rng(in_tdata[83:72]);
            vc_r  <= in_rng(in_tdata[95:84]);
            case (in_tuser)
              MODE_FACE: state_r <= S_VRA;
              MODE_READ: state_r <= S_NRD;
              default:   state_r <= S_IDLE;
            endcase
          end
        end
        S_NRD: state_r <= S_NCAP;
        S_NCAP: begin
          res_r.x     <= vi_r ? comp_t'(n_rdata[15:0])  : '0;
          res_r.y     <= vi_r ? comp_t'(n_rdata[31:16]) : '0;
          res_r.z     <= vi_r ? comp_t'(n_rdata[47:32]) : '0;
          res_r.degen <= 1'b0;
          face_r      <= 1'b0;
          state_r     <= S_OUT;
        end
        S_VRA: state_r <= S_VRB;
        S_VRB: begin
          pa_r    <= va_r ? v_rdata : '0;
          state_r <= S_VRC;
        end
        S_VRC: begin
          pb_r    <= vb_r ? v_rdata : '0;
          state_r <= S_VCAP;
        end
        S_VCAP: begin
          for (int i = 0; i < 3; i++) begin
            e1_r[i] <= EDGE_W'($signed(pb_r[COORD_W*i +: COORD_W]))
                     - EDGE_W'($signed(pa_r[COORD_W*i +: COORD_W]));
            e2_r[i] <= EDGE_W'($signed(pc_c[COORD_W*i +: COORD_W]))
                     - EDGE_W'($signed(pb_r[COORD_W*i +: COORD_W]));
            cr_r[i] <= '0;
          end
          cnt_r   <= '0;
          state_r <= S_CROSS;
        end
        S_CROSS: begin
          prod_r <= op_a * op_b;
          cnt_r  <= cnt_r + 3'd1;
          // products alternate plus and minus terms of one component
          if (cnt_r != 3'd0) begin
            if (acc_ix[0]) cr_r[acc_ix[2:1]] <= cr_r[acc_ix[2:1]] - prod_ext;
            else           cr_r[acc_ix[2:1]] <= cr_r[acc_ix[2:1]] + prod_ext;
          end
          if (cnt_r == 3'd6) begin
            start_r <= 1'b1;
            state_r <= S_NORM;
          end
        end
        S_NORM: begin
          if (norm_done) begin
            res_r   <= norm_res;
            face_r  <= 1'b1;
            state_r <= S_WRA;
          end
        end
        S_WRA: state_r <= S_WRB;
        S_WRB: state_r <= S_WRC;
        S_WRC: state_r <= S_OUT;
        S_OUT: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {res_r.z, res_r.y, res_r.x};
            out_tuser_r  <= {face_r, res_r.degen};
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

/* sv/tfn_checker.sv */
// ----------------------------------------------------------------------------
// tfn_checker
// port-level checks of the face normal block, bound to the top level
// ----------------------------------------------------------------------------
`include "triangle_face_normal_scatter_core_macros.svh"

module tfn_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [1:0]  out_tuser
);

  logic signed [15:0] nx, ny, nz;
  logic               in_range;

  assign nx = out_tdata[15:0];
  assign ny = out_tdata[31:16];
  assign nz = out_tdata[47:32];
  assign in_range = (nx <= 16'sd16384) && (nx >= -16'sd16384)
                 && (ny <= 16'sd16384) && (ny >= -16'sd16384)
                 && (nz <= 16'sd16384) && (nz >= -16'sd16384);

  // a stalled result beat holds
  `TFN_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  // degenerate comes only with face results
  `TFN_ASSERT_IMP(a_degen_face, clk, rst_n, out_tvalid && out_tuser[0], out_tuser[1])
  // degenerate result carries a zero normal
  `TFN_ASSERT_IMP(a_degen_zero, clk, rst_n, out_tvalid && out_tuser[0], out_tdata == 48'd0)
  // components stay within unit range
  `TFN_ASSERT_IMP(a_unit_range, clk, rst_n, out_tvalid, in_range)

endmodule

bind triangle_face_normal_scatter_core tfn_checker u_tfn_checker (.*);

/* dv/tb_triangle_face_normal_scatter_core.sv */
// ----------------------------------------------------------------------------
// tb_triangle_face_normal_scatter_core
// stream testbench: loads vertices, processes faces and reads back normals,
// predicting each result beat with its own fixed point normal calculation
// ----------------------------------------------------------------------------
module tb_triangle_face_normal_scatter_core;
  import tfn_pkg::*;

  typedef struct {
    logic [1:0]  mode;
    logic [11:0] vidx;
    logic [15:0] cx, cy, cz;
    logic [11:0] ca, cb, cc;
  } mesh_beat_t;

  typedef struct {
    logic [15:0] nx, ny, nz;
    logic        degen;
    logic        face;
  } normal_beat_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [95:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;

  triangle_face_normal_scatter_core dut (.*);

  mesh_beat_t   pending_q[$];
  normal_beat_t expected_normals[$];
  logic signed [15:0] vtx_pos[4096][3];
  // normal store starts cleared
  logic signed [15:0] vtx_nrm[4096][3] = '{default: '0};
  bit           vtx_loaded[4096];
  int           loaded_list[$];
  int           errors;
  int           cycles;
  int           in_idle, out_idle;
  bit           no_idle;
  bit           hold_for_drain;
  bit           stim_done;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  function automatic longint unsigned root_floor(input longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // cross product scaled to unit length in q1.14, plus store update
  function automatic normal_beat_t face_normal(input logic [11:0] ia, ib, ic);
    normal_beat_t    res;
    longint          p[3][3];
    longint          e1[3], e2[3], cr[3];
    longint unsigned mag[3], m, s, r, q;
    int              len, k;
    logic [11:0]     idx[3];
    idx[0] = ia; idx[1] = ib; idx[2] = ic;
    for (int j = 0; j < 3; j++)
      for (k = 0; k < 3; k++) p[j][k] = vtx_pos[idx[j]][k];
    for (k = 0; k < 3; k++) begin
      e1[k] = p[1][k] - p[0][k];
      e2[k] = p[2][k] - p[1][k];
    end
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    m = 0;
    for (k = 0; k < 3; k++) begin
      mag[k] = cr[k] < 0 ? -cr[k] : cr[k];
      if (mag[k] > m) m = mag[k];
    end
    res.face = 1'b1;
    res.degen = (m == 0);
    res.nx = 0; res.ny = 0; res.nz = 0;
    if (m != 0) begin
      len = 0;
      while (len < 63 && (m >> len) != 0) len++;
      s = 0;
      for (k = 0; k < 3; k++) begin
        if (len > 23) mag[k] >>= (len - 23);
        else if (len < 23) mag[k] <<= (23 - len);
        s += mag[k] * mag[k];
      end
      r = root_floor(s << 14);
      for (k = 0; k < 3; k++) begin
        q = ((mag[k] << 21) + (r >> 1)) / r;
        if (q > 16384) q = 16384;
        if (k == 0) res.nx = cr[k] < 0 ? -q : q;
        if (k == 1) res.ny = cr[k] < 0 ? -q : q;
        if (k == 2) res.nz = cr[k] < 0 ? -q : q;
      end
    end
    for (int j = 0; j < 3; j++) begin
      vtx_nrm[idx[j]][0] = res.nx;
      vtx_nrm[idx[j]][1] = res.ny;
      vtx_nrm[idx[j]][2] = res.nz;
    end
    return res;
  endfunction

  function automatic void predict_beat(input mesh_beat_t b);
    normal_beat_t res;
    case (b.mode)
      MODE_LOAD: begin
        vtx_pos[b.vidx][0] = b.cx;
        vtx_pos[b.vidx][1] = b.cy;
        vtx_pos[b.vidx][2] = b.cz;
      end
      MODE_FACE: expected_normals.push_back(face_normal(b.ca, b.cb, b.cc));
      MODE_READ: begin
        res.nx = vtx_nrm[b.vidx][0];
        res.ny = vtx_nrm[b.vidx][1];
        res.nz = vtx_nrm[b.vidx][2];
        res.degen = 1'b0;
        res.face = 1'b0;
        expected_normals.push_back(res);
      end
      default: ;
    endcase
  endfunction

  function automatic mesh_beat_t load_beat(input int v, input logic [15:0] x, y, z);
    mesh_beat_t b;
    b = '{default: '0};
    b.mode = MODE_LOAD;
    b.vidx = v; b.cx = x; b.cy = y; b.cz = z;
    b.ca = $urandom; b.cb = $urandom; b.cc = $urandom;
    if (!vtx_loaded[v]) begin
      vtx_loaded[v] = 1'b1;
      loaded_list.push_back(v);
    end
    return b;
  endfunction

  function automatic mesh_beat_t face_beat(input int a, b, c);
    mesh_beat_t f;
    f.mode = MODE_FACE;
    f.ca = a; f.cb = b; f.cc = c;
    f.vidx = $urandom; f.cx = $urandom; f.cy = $urandom; f.cz = $urandom;
    return f;
  endfunction

  function automatic mesh_beat_t read_beat(input int v);
    mesh_beat_t r;
    r = '{default: '0};
    r.mode = MODE_READ;
    r.vidx = v;
    r.cx = $urandom; r.cy = $urandom; r.cz = $urandom;
    r.ca = $urandom; r.cb = $urandom; r.cc = $urandom;
    return r;
  endfunction

  function automatic int any_loaded();
    return loaded_list[$urandom_range(loaded_list.size() - 1)];
  endfunction

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return $urandom_range(16'h00ff);
      default: return $urandom;
    endcase
  endfunction

  // directed part, then random mesh traffic; faces use loaded vertices only
  initial begin
    mesh_beat_t b;
    int         v;
    hold_for_drain = 1'b0;
    no_idle = 1'b0;
    pending_q.push_back(read_beat(4095));
    pending_q.push_back(read_beat(0));
    pending_q.push_back(load_beat(0, 16'h0000, 16'h0000, 16'h0000));
    pending_q.push_back(load_beat(1, 16'h7fff, 16'h0000, 16'h0000));
    pending_q.push_back(load_beat(2, 16'h7fff, 16'h7fff, 16'h0000));
    pending_q.push_back(load_beat(4095, 16'h8000, 16'h8000, 16'h8000));
    pending_q.push_back(load_beat(3, 16'h7fff, 16'h8000, 16'h7fff));
    pending_q.push_back(load_beat(4, 16'h0001, 16'h0000, 16'hffff));
    pending_q.push_back(face_beat(0, 1, 2));
    pending_q.push_back(read_beat(2));
    pending_q.push_back(face_beat(0, 0, 1));      // zero length normal
    pending_q.push_back(read_beat(0));
    pending_q.push_back(read_beat(1));
    pending_q.push_back(face_beat(4095, 3, 1));
    pending_q.push_back(face_beat(3, 4095, 4));
    pending_q.push_back(face_beat(1, 0, 4));
    pending_q.push_back(read_beat(4095));
    b = read_beat(5); b.mode = 2'b11;            // unused mode, ignored
    b.vidx = 12'hfff; b.cx = 16'hffff; b.cy = 16'hffff; b.cz = 16'hffff;
    b.ca = 12'hfff; b.cb = 12'hfff; b.cc = 12'hfff;
    pending_q.push_back(b);
    pending_q.push_back(read_beat(4));
    for (int i = 0; i < 1030; i++) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          v = $urandom_range(7) == 0 ? $urandom_range(4095) : $urandom_range(63);
          pending_q.push_back(load_beat(v, rand_coord(), rand_coord(), rand_coord()));
        end
        3, 4, 5, 6: begin
          if ($urandom_range(9) == 0) v = any_loaded();
          pending_q.push_back(face_beat(any_loaded(),
                                        $urandom_range(9) == 0 ? v : any_loaded(),
                                        any_loaded()));
        end
        7, 8: pending_q.push_back(read_beat($urandom_range(3) == 0 ?
                                            $urandom_range(4095) : $urandom_range(63)));
        default: begin
          b = read_beat(0);
          b.mode = 2'b11;
          b.vidx = $urandom;
          pending_q.push_back(b);
        end
      endcase
    end
  end

  // driver
  always @(posedge clk) begin
    mesh_beat_t b;
    bit         acc;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_idle   <= 0;
    end else begin
      acc = in_tvalid && in_tready;
      if (acc) predict_beat(pending_q.pop_front());
      if (in_tvalid && !in_tready) begin
        // hold the current beat
      end else if (in_idle > 0) begin
        in_tvalid <= 1'b0;
        in_idle   <= in_idle - 1;
      end else if (hold_for_drain && expected_normals.size() != 0) begin
        in_tvalid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        b = pending_q[0];
        if (acc && !no_idle && $urandom_range(7) == 0) begin
          in_tvalid <= 1'b0;
          in_idle   <= $urandom_range(1, 15) - 1;
        end else begin
          in_tvalid <= 1'b1;
          in_tuser  <= b.mode;
          in_tdata  <= {b.cc, b.cb, b.ca, b.cz, b.cy, b.cx, b.vidx};
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // phase control: pause for a full drain once, no idling near the end
  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_for_drain && expected_normals.size() == 0 && !in_tvalid)
        hold_for_drain <= 1'b0;
      else if (pending_q.size() == 600) hold_for_drain <= 1'b1;
      if (pending_q.size() < 150) no_idle <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    normal_beat_t w;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_idle   <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_normals.size() == 0) begin
          $display("unexpected result beat %h %h", out_tdata, out_tuser);
          errors++;
        end else begin
          w = expected_normals.pop_front();
          if (out_tdata[15:0] !== w.nx) report_mismatch("normal_x", out_tdata[15:0], w.nx);
          if (out_tdata[31:16] !== w.ny) report_mismatch("normal_y", out_tdata[31:16], w.ny);
          if (out_tdata[47:32] !== w.nz) report_mismatch("normal_z", out_tdata[47:32], w.nz);
          if (out_tuser[0] !== w.degen) report_mismatch("degenerate", out_tuser[0], w.degen);
          if (out_tuser[1] !== w.face) report_mismatch("from_face", out_tuser[1], w.face);
        end
      end
      if (out_idle > 0) begin
        out_tready <= 1'b0;
        out_idle   <= out_idle - 1;
      end else if (!no_idle && $urandom_range(11) == 0) begin
        out_tready <= 1'b0;
        out_idle   <= $urandom_range(1, 15) - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    errors    = 0;
    cycles    = 0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    out_tready = 1'b0;
    rst_n     = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_q.size() != 0 || in_tvalid || expected_normals.size() != 0) begin
      @(posedge clk);
      cycles++;
      if (cycles > 600000) begin
        $display("** triangle_face_normal_scatter_core: FAILED **");
        $finish;
      end
    end
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("** triangle_face_normal_scatter_core: PASSED **");
    end else begin
      $display("** triangle_face_normal_scatter_core: FAILED **");
    end
    $finish;
  end

endmodule
